### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

### rtl/bldq_pkg.sv
// ----------------------------------------------------------------------------
// bldq_pkg
// widths, operation and status codes, sequencer states for the list engine
// ----------------------------------------------------------------------------
package bldq_pkg;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 6;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int DUMP_LIMIT       = 32;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_RD,
      ST_POP_CAP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_RESP,
      ST_DUMP_RD,
      ST_DUMP_OUT
   } state_type;

endpackage

### rtl/bldq_req_if.sv
// ----------------------------------------------------------------------------
// bldq_req_if
// request channel: operation, word and position under valid/ready
// ----------------------------------------------------------------------------
interface bldq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [bldq_pkg::MODE_W-1:0]          mode;
   logic signed [bldq_pkg::VALUE_W-1:0]  value;
   logic [bldq_pkg::POS_W-1:0]           position;

   modport source (output valid, mode, value, position, input ready);
   modport sink   (input valid, mode, value, position, output ready);
endinterface

### rtl/bldq_rsp_if.sv
// ----------------------------------------------------------------------------
// bldq_rsp_if
// response channel: value, status, length and last flag under valid/ready
// ----------------------------------------------------------------------------
interface bldq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bldq_pkg::VALUE_W-1:0]  result_value;
   logic [bldq_pkg::STATUS_W-1:0]        status;
   logic [bldq_pkg::LEN_W-1:0]           length;
   logic                                 last;

   modport source (output valid, result_value, status, length, last, input ready);
   modport sink   (input valid, result_value, status, length, last, output ready);
endinterface

### rtl/bounded_list_deque_engine_core.sv
// ----------------------------------------------------------------------------
// bounded_list_deque_engine_core
// ordered list of signed words with push/pop at both ends, insert after a
// position and an in-order dump, kept in one memory and shifted by a sequencer
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake      word
//  req_chan   in    valid/ready    mode, value, position
//  rsp_chan   out   valid/ready    result_value, status, length, last
//
// one request at a time: req_chan.ready is high only in the idle state
// refusals go from decode straight to the response; push back passes one put, pop back a read and capture
// each entry moved by a shift is a memory read, then a write back:
// push front on n entries moves all n of them, pop front the n - 1 behind the head
// a dump reads each entry, then sends it; a stalled rsp_chan holds each word and stretches it
// synchronous active-high reset empties the list; the store itself is not cleared

`include "assert_macros.svh"

module bounded_list_deque_engine_core #(
   parameter int CAPACITY = bldq_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bldq_req_if.sink    req_chan,
   bldq_rsp_if.source  rsp_chan
);

   // count needs to hold CAPACITY itself, addresses only up to CAPACITY-1
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   // sequencer
   bldq_pkg::state_type state_ff, state_in;

   // captured request
   logic [bldq_pkg::MODE_W-1:0]          mode_ff, mode_in;
   logic signed [bldq_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [bldq_pkg::POS_W-1:0]           pos_ff, pos_in;

   // list length and shift loop control
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  stop_ff, stop_in;
   logic           dir_up_ff, dir_up_in;

   // result being built
   logic signed [bldq_pkg::VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [bldq_pkg::STATUS_W-1:0]        res_status_ff, res_status_in;

   // response output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [bldq_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [bldq_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [bldq_pkg::LEN_W-1:0]           rsp_length_ff, rsp_length_in;
   logic                                 rsp_last_ff, rsp_last_in;

   // entry store, registered read port
   logic signed [bldq_pkg::VALUE_W-1:0]  entry_mem [CAPACITY];
   logic signed [bldq_pkg::VALUE_W-1:0]  rd_data_ff;

   // control outputs of the sequencer
   logic                                 req_ready;
   logic                                 mem_re;
   logic [AW-1:0]                        rd_addr;
   logic                                 mem_we;
   logic [AW-1:0]                        wr_addr;
   logic signed [bldq_pkg::VALUE_W-1:0]  wr_data;
   logic                                 out_load;

   // decode helpers
   logic           req_accept;
   logic           out_free;
   logic           is_full;
   logic           is_empty;
   logic           pos_bad;
   logic           loop_done;
   logic [CW-1:0]  idx_step;
   logic [CW-1:0]  dump_stop;

   assign req_accept = req_chan.valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign is_full    = (count_ff == CW'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign pos_bad    = (32'(pos_ff) >= 32'(count_ff));
   assign loop_done  = (idx_ff == stop_ff);

   // the one shared index unit: step down for push and insert shifts, up otherwise
   assign idx_step = dir_up_ff ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));

   // index of the final dumped entry
   assign dump_stop = (32'(count_ff) >= 32'(bldq_pkg::DUMP_LIMIT))
                      ? CW'(bldq_pkg::DUMP_LIMIT - 1) : (count_ff - CW'(1));

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bldq_pkg::ST_IDLE: begin
            if (req_accept) state_in = bldq_pkg::ST_DECODE;
         end
         bldq_pkg::ST_DECODE: begin
            state_in = bldq_pkg::ST_RESP;
            case (mode_ff)
               bldq_pkg::MODE_PUSH_FRONT,
               bldq_pkg::MODE_PUSH_BACK: begin
                  if (!is_full) state_in = bldq_pkg::ST_SHIFT_RD;
               end
               bldq_pkg::MODE_POP_FRONT,
               bldq_pkg::MODE_POP_BACK: begin
                  if (!is_empty) state_in = bldq_pkg::ST_POP_RD;
               end
               bldq_pkg::MODE_INSERT: begin
                  if (!is_full && !pos_bad) state_in = bldq_pkg::ST_SHIFT_RD;
               end
               bldq_pkg::MODE_DUMP: begin
                  if (!is_empty) state_in = bldq_pkg::ST_DUMP_RD;
               end
               default: state_in = bldq_pkg::ST_RESP;
            endcase
         end
         bldq_pkg::ST_POP_RD: state_in = bldq_pkg::ST_POP_CAP;
         bldq_pkg::ST_POP_CAP: begin
            if (mode_ff == bldq_pkg::MODE_POP_FRONT) state_in = bldq_pkg::ST_SHIFT_RD;
            else state_in = bldq_pkg::ST_RESP;
         end
         bldq_pkg::ST_SHIFT_RD: begin
            if (!loop_done) state_in = bldq_pkg::ST_SHIFT_WR;
            else if (dir_up_ff) state_in = bldq_pkg::ST_PUT;
            else state_in = bldq_pkg::ST_RESP;
         end
         bldq_pkg::ST_SHIFT_WR: state_in = bldq_pkg::ST_SHIFT_RD;
         bldq_pkg::ST_PUT: state_in = bldq_pkg::ST_RESP;
         bldq_pkg::ST_RESP: begin
            if (out_free) state_in = bldq_pkg::ST_IDLE;
         end
         bldq_pkg::ST_DUMP_RD: state_in = bldq_pkg::ST_DUMP_OUT;
         bldq_pkg::ST_DUMP_OUT: begin
            if (out_free) begin
               if (loop_done) state_in = bldq_pkg::ST_IDLE;
               else state_in = bldq_pkg::ST_DUMP_RD;
            end
         end
         default: state_in = bldq_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer outputs: handshake, memory port, response load
   // ------------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      rd_addr   = idx_ff[AW-1:0];
      mem_we    = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_data_ff;
      out_load  = 1'b0;
      case (state_ff)
         bldq_pkg::ST_IDLE: req_ready = 1'b1;
         bldq_pkg::ST_POP_RD: begin
            mem_re = 1'b1;
            if (mode_ff == bldq_pkg::MODE_POP_FRONT) rd_addr = '0;
            else rd_addr = AW'(count_ff - CW'(1));
         end
         bldq_pkg::ST_SHIFT_RD: begin
            // fetch the neighbor that moves into idx
            if (!loop_done) begin
               mem_re  = 1'b1;
               rd_addr = idx_step[AW-1:0];
            end
         end
         bldq_pkg::ST_SHIFT_WR: mem_we = 1'b1;
         bldq_pkg::ST_PUT: begin
            mem_we  = 1'b1;
            wr_addr = stop_ff[AW-1:0];
            wr_data = value_ff;
         end
         bldq_pkg::ST_RESP: out_load = out_free;
         bldq_pkg::ST_DUMP_RD: mem_re = 1'b1;
         bldq_pkg::ST_DUMP_OUT: out_load = out_free;
         default: req_ready = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      mode_in       = mode_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      stop_in       = stop_ff;
      dir_up_in     = dir_up_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_chan.ready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         bldq_pkg::ST_IDLE: begin
            if (req_accept) begin
               mode_in  = req_chan.mode;
               value_in = req_chan.value;
               pos_in   = req_chan.position;
            end
         end
         bldq_pkg::ST_DECODE: begin
            res_value_in  = '0;
            res_status_in = bldq_pkg::STATUS_OK;
            case (mode_ff)
               bldq_pkg::MODE_PUSH_FRONT,
               bldq_pkg::MODE_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = bldq_pkg::STATUS_FULL;
                  end else begin
                     // open a hole at the slot by moving entries up
                     dir_up_in = 1'b1;
                     idx_in    = count_ff;
                     stop_in   = (mode_ff == bldq_pkg::MODE_PUSH_FRONT) ? '0 : count_ff;
                  end
               end
               bldq_pkg::MODE_POP_FRONT,
               bldq_pkg::MODE_POP_BACK: begin
                  if (is_empty) res_status_in = bldq_pkg::STATUS_EMPTY;
               end
               bldq_pkg::MODE_INSERT: begin
                  if (is_full) begin
                     res_status_in = bldq_pkg::STATUS_FULL;
                  end else if (pos_bad) begin
                     res_status_in = bldq_pkg::STATUS_RANGE;
                  end else begin
                     dir_up_in = 1'b1;
                     idx_in    = count_ff;
                     stop_in   = CW'(pos_ff) + CW'(1);
                  end
               end
               bldq_pkg::MODE_DUMP: begin
                  if (is_empty) begin
                     res_status_in = bldq_pkg::STATUS_EMPTY;
                  end else begin
                     dir_up_in = 1'b0;
                     idx_in    = '0;
                     stop_in   = dump_stop;
                  end
               end
               default: res_status_in = bldq_pkg::STATUS_OK;
            endcase
         end
         bldq_pkg::ST_POP_CAP: begin
            res_value_in = rd_data_ff;
            if (mode_ff == bldq_pkg::MODE_POP_FRONT) begin
               // close the gap at the front by moving entries down
               dir_up_in = 1'b0;
               idx_in    = '0;
               stop_in   = count_ff - CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         bldq_pkg::ST_SHIFT_RD: begin
            if (loop_done && !dir_up_ff) count_in = count_ff - CW'(1);
         end
         bldq_pkg::ST_SHIFT_WR: idx_in = idx_step;
         bldq_pkg::ST_PUT: count_in = count_ff + CW'(1);
         bldq_pkg::ST_RESP: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_length_in = bldq_pkg::LEN_W'(count_ff);
               rsp_last_in   = 1'b1;
            end
         end
         bldq_pkg::ST_DUMP_OUT: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_data_ff;
               rsp_status_in = bldq_pkg::STATUS_OK;
               rsp_length_in = bldq_pkg::LEN_W'(count_ff);
               rsp_last_in   = loop_done;
               idx_in        = idx_step;
            end
         end
         default: rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      endcase
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bldq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      stop_ff       <= stop_in;
      dir_up_ff     <= dir_up_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) entry_mem[wr_addr] <= wr_data;
      if (mem_re) rd_data_ff <= entry_mem[rd_addr];
   end

   // ------------------------------------------------------------------------
   // ports
   // ------------------------------------------------------------------------
   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.length       = rsp_length_ff;
   assign rsp_chan.last         = rsp_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `ASSERT_NEVER(a_count_bound, 32'(count_ff) > 32'(CAPACITY), "list length above capacity")
   `ASSERT_NEVER(a_no_clobber, out_load && rsp_valid_ff && !rsp_chan.ready, "word overwritten")
   `ASSERT_IMPLIES(a_shift_addr, state_ff == bldq_pkg::ST_SHIFT_WR, idx_ff < CW'(CAPACITY), "bad shift")
   `ASSERT_NEXT(a_idle_count, state_ff == bldq_pkg::ST_IDLE, count_ff == $past(count_ff), "idle len")

endmodule
